FILE: sv/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the bmp24 to rgb565 stream decoder
// image geometry, header constants, status codes and the result item layout
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // display geometry
  localparam int unsigned ImageWidth    = 64;
  localparam int unsigned ImageHeight   = 64;

  // file layout
  localparam int unsigned HdrLen        = 54;
  localparam int unsigned RowPixelBytes = ImageWidth * 3;
  localparam int unsigned RowStride     = ((RowPixelBytes + 3) / 4) * 4;

  // counter widths
  localparam int unsigned RowW          = $clog2(ImageHeight + 1);
  localparam int unsigned ColW          = $clog2(ImageWidth + 1);
  localparam int unsigned StrideW       = $clog2(RowStride);

  // header values that are accepted
  localparam logic [15:0] BmpSignature  = 16'h4D42;
  localparam logic [31:0] MinDibSize    = 32'd40;
  localparam logic [15:0] BitsPerPixel  = 16'd24;
  localparam logic [15:0] PlaneCount    = 16'd1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StShort     = 3'd1,
    StSignature = 3'd2,
    StDib       = 3'd3,
    StFormat    = 3'd4,
    StSize      = 3'd5,
    StOffset    = 3'd6,
    StTruncated = 3'd7
  } status_e;

  typedef enum logic {
    KindPixel  = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] color;
    status_e     status;
    logic        last;
  } result_t;

endpackage

FILE: sv/bmp24_to_rgb565_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream_decoder: streaming bmp file to rgb565 pixel decoder
// parses a 24 bit bmp byte stream and writes out positioned rgb565 pixels
// ----------------------------------------------------------------------------
// usage
// - slave stream: one file byte per item in tdata, tlast on the final byte
// - master stream: pixel items (tuser 0) carry display row, column and color;
//   the last item caused by the final byte of a file is a status item (tuser 1);
//   tlast marks the final result item of each input byte
// - cfg channel: one bit, 1 swaps red and blue, always ready; write it only
//   while no file is in flight
// - path: an input byte is registered, then decoded into the result queue
//   once the queue has room; the master side is driven from the queue head
// - throughput: one byte per cycle while the result queue has room; a final
//   byte giving both a pixel and a status item waits for an empty queue
// - a stalled receiver fills the two-entry result queue, then tready drops on
//   the slave side; nothing is dropped
// - reset clears the parser, the swap bit and both queues; after each status
//   item the parser is back at its reset state and the next byte opens a file
module bmp24_to_rgb565_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tlast,   // end_of_file
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] pixel_row, [11:6] pixel_column,
                                      // [27:12] pixel_color, [30:28] status_code
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last_result
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // swap_red_blue
);

  // swap register
  logic swap_q;

  // input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eof_q;

  // result queue, entry 0 is the head
  bmpd_pkg::result_t q0_q, q0_d, q1_q, q1_d;
  logic [1:0]        cnt_q, cnt_d;

  logic              pop;
  logic              step;
  logic [1:0]        rem;
  logic              pix_valid, stat_valid;
  bmpd_pkg::result_t pix_res, stat_res;
  logic              push_a, push_b;
  bmpd_pkg::result_t res_a;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (cfg_valid_i) begin
      swap_q <= cfg_data_i;
    end
  end

  // decode one byte when the queue has room for everything it causes
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign rem  = cnt_q - {1'b0, pop};
  assign step = in_v_q && ((rem == 2'd0) || (rem == 2'd1 && !(pix_valid && stat_valid)));

  assign s_axis_tready = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tlast;
    end
  end

  bmpd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte_q),
    .eof_i        (in_eof_q),
    .swap_i       (swap_q),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix_res),
    .stat_valid_o (stat_valid),
    .stat_o       (stat_res)
  );

  // pixel goes ahead of the status when a byte causes both
  assign push_a = step && (pix_valid || stat_valid);
  assign push_b = step && pix_valid && stat_valid;
  assign res_a  = pix_valid ? pix_res : stat_res;

  always_comb begin
    q0_d  = q0_q;
    q1_d  = q1_q;
    cnt_d = cnt_q;
    if (pop) begin
      q0_d  = q1_q;
      cnt_d = cnt_d - 2'd1;
    end
    if (push_a) begin
      if (cnt_d == 2'd0) begin
        q0_d = res_a;
      end else begin
        q1_d = res_a;
      end
      cnt_d = cnt_d + 2'd1;
    end
    if (push_b) begin
      q1_d  = stat_res;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {1'b0, q0_q.status, q0_q.color, q0_q.col, q0_q.row};
  assign m_axis_tuser  = q0_q.kind;
  assign m_axis_tlast  = q0_q.last;

  // queue never holds more than two results
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overflow");

  // a full queue that is not drained blocks decoding
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |-> !step)
    else $error("decode step into a full queue");

  // a status result always closes its input byte
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("status item without last flag");

  // pixel results carry no status code
  a_pixel_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[30:28] == bmpd_pkg::StOk))
    else $error("pixel item with status code");

endmodule

FILE: sv/bmpd_core.sv
// ----------------------------------------------------------------------------
// bmpd_core: header parser and pixel assembler
// takes one file byte per step and gives the pixel and status results it causes
// ----------------------------------------------------------------------------
module bmpd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               eof_i,
  input  logic               swap_i,
  output logic               pix_valid_o,
  output bmpd_pkg::result_t  pix_o,
  output logic               stat_valid_o,
  output bmpd_pkg::result_t  stat_o
);

  // control state
  logic [31:0]                    pos_q, pos_d;
  bmpd_pkg::status_e              err_q, err_d;
  logic [bmpd_pkg::RowW-1:0]      row_q, row_d;
  logic [bmpd_pkg::ColW-1:0]      col_q, col_d;
  logic [bmpd_pkg::StrideW-1:0]   wrow_q, wrow_d;
  logic [1:0]                     phase_q, phase_d;

  // header fields and partial pixel, always written before they are read
  logic [31:0] off_q, dib_q, width_q, height_q, comp_q;
  logic [15:0] sig_q, planes_q, bpp_q;
  logic [7:0]  blue_q, green_q;

  logic        hdr_byte;
  logic        pix_area;
  logic        in_pix;
  logic        pix_emit;
  logic        bottom_up;
  logic [bmpd_pkg::RowW-1:0] drow;
  logic [7:0]  red_ch, blue_ch;
  bmpd_pkg::status_e chk_code;
  bmpd_pkg::status_e stat_code;

  assign hdr_byte  = pos_q < 32'(bmpd_pkg::HdrLen);
  assign bottom_up = ~height_q[31];
  assign pix_area  = ~hdr_byte && (err_q == bmpd_pkg::StOk) && (pos_q >= off_q) &&
                     (row_q < bmpd_pkg::RowW'(bmpd_pkg::ImageHeight));
  assign in_pix    = wrow_q < bmpd_pkg::StrideW'(bmpd_pkg::RowPixelBytes);
  assign pix_emit  = pix_area && in_pix && (phase_q == 2'd2);

  // header check, in priority order
  always_comb begin
    if (sig_q != bmpd_pkg::BmpSignature) begin
      chk_code = bmpd_pkg::StSignature;
    end else if (dib_q < bmpd_pkg::MinDibSize) begin
      chk_code = bmpd_pkg::StDib;
    end else if (planes_q != bmpd_pkg::PlaneCount || comp_q != 32'd0 ||
                 bpp_q != bmpd_pkg::BitsPerPixel) begin
      chk_code = bmpd_pkg::StFormat;
    end else if (width_q != 32'(bmpd_pkg::ImageWidth) ||
                 (height_q != 32'(bmpd_pkg::ImageHeight) &&
                  height_q != (32'd0 - 32'(bmpd_pkg::ImageHeight)))) begin
      chk_code = bmpd_pkg::StSize;
    end else if (off_q < 32'(bmpd_pkg::HdrLen)) begin
      chk_code = bmpd_pkg::StOffset;
    end else begin
      chk_code = bmpd_pkg::StOk;
    end
  end

  // next control state
  always_comb begin
    pos_d   = (pos_q != 32'hFFFF_FFFF) ? pos_q + 32'd1 : pos_q;
    err_d   = err_q;
    row_d   = row_q;
    col_d   = col_q;
    wrow_d  = wrow_q;
    phase_d = phase_q;
    if (hdr_byte && pos_q[5:0] == 6'(bmpd_pkg::HdrLen - 1)) begin
      err_d = chk_code;
    end
    if (pix_area) begin
      if (in_pix) begin
        phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
        if (pix_emit) begin
          col_d = col_q + bmpd_pkg::ColW'(1);
        end
      end
      if (wrow_q == bmpd_pkg::StrideW'(bmpd_pkg::RowStride - 1)) begin
        wrow_d  = '0;
        phase_d = 2'd0;
        col_d   = '0;
        row_d   = row_q + bmpd_pkg::RowW'(1);
      end else begin
        wrow_d = wrow_q + bmpd_pkg::StrideW'(1);
      end
    end
  end

  // status at end of file
  always_comb begin
    if (pos_d < 32'(bmpd_pkg::HdrLen)) begin
      stat_code = bmpd_pkg::StShort;
    end else if (err_d != bmpd_pkg::StOk) begin
      stat_code = err_d;
    end else if (row_d < bmpd_pkg::RowW'(bmpd_pkg::ImageHeight)) begin
      stat_code = bmpd_pkg::StTruncated;
    end else begin
      stat_code = bmpd_pkg::StOk;
    end
  end

  assign drow    = bottom_up ? bmpd_pkg::RowW'(bmpd_pkg::ImageHeight - 1) - row_q : row_q;
  assign red_ch  = swap_i ? blue_q : byte_i;
  assign blue_ch = swap_i ? byte_i : blue_q;

  assign pix_valid_o  = pix_emit;
  assign pix_o.kind   = bmpd_pkg::KindPixel;
  assign pix_o.row    = 6'(drow);
  assign pix_o.col    = 6'(col_q);
  assign pix_o.color  = {red_ch[7:3], green_q[7:2], blue_ch[7:3]};
  assign pix_o.status = bmpd_pkg::StOk;
  assign pix_o.last   = ~eof_i;

  assign stat_valid_o  = eof_i;
  assign stat_o.kind   = bmpd_pkg::KindStatus;
  assign stat_o.row    = 6'd0;
  assign stat_o.col    = 6'd0;
  assign stat_o.color  = 16'd0;
  assign stat_o.status = stat_code;
  assign stat_o.last   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      err_q   <= bmpd_pkg::StOk;
      row_q   <= '0;
      col_q   <= '0;
      wrow_q  <= '0;
      phase_q <= '0;
    end else if (step_i) begin
      if (eof_i) begin
        pos_q   <= '0;
        err_q   <= bmpd_pkg::StOk;
        row_q   <= '0;
        col_q   <= '0;
        wrow_q  <= '0;
        phase_q <= '0;
      end else begin
        pos_q   <= pos_d;
        err_q   <= err_d;
        row_q   <= row_d;
        col_q   <= col_d;
        wrow_q  <= wrow_d;
        phase_q <= phase_d;
      end
    end
  end

  // header gathering and pixel byte capture
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (hdr_byte) begin
        case (pos_q[5:0])
          6'd0:  sig_q[7:0]       <= byte_i;
          6'd1:  sig_q[15:8]      <= byte_i;
          6'd10: off_q[7:0]       <= byte_i;
          6'd11: off_q[15:8]      <= byte_i;
          6'd12: off_q[23:16]     <= byte_i;
          6'd13: off_q[31:24]     <= byte_i;
          6'd14: dib_q[7:0]       <= byte_i;
          6'd15: dib_q[15:8]      <= byte_i;
          6'd16: dib_q[23:16]     <= byte_i;
          6'd17: dib_q[31:24]     <= byte_i;
          6'd18: width_q[7:0]     <= byte_i;
          6'd19: width_q[15:8]    <= byte_i;
          6'd20: width_q[23:16]   <= byte_i;
          6'd21: width_q[31:24]   <= byte_i;
          6'd22: height_q[7:0]    <= byte_i;
          6'd23: height_q[15:8]   <= byte_i;
          6'd24: height_q[23:16]  <= byte_i;
          6'd25: height_q[31:24]  <= byte_i;
          6'd26: planes_q[7:0]    <= byte_i;
          6'd27: planes_q[15:8]   <= byte_i;
          6'd28: bpp_q[7:0]       <= byte_i;
          6'd29: bpp_q[15:8]      <= byte_i;
          6'd30: comp_q[7:0]      <= byte_i;
          6'd31: comp_q[15:8]     <= byte_i;
          6'd32: comp_q[23:16]    <= byte_i;
          6'd33: comp_q[31:24]    <= byte_i;
          default: ;
        endcase
      end else if (pix_area && in_pix) begin
        if (phase_q == 2'd0) begin
          blue_q <= byte_i;
        end else if (phase_q == 2'd1) begin
          green_q <= byte_i;
        end
      end
    end
  end

endmodule

FILE: tb/bmpd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_result_checker: result predictor and scoreboard for the bmp decoder
// watches the config, input and result channels, decodes each accepted file
// byte on its own and compares every result item field by field
// ----------------------------------------------------------------------------
module bmpd_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          error_count_o,
  output int          pending_o,
  output int          pixels_seen_o,
  output int          reports_seen_o
);

  logic                 swap_rb;
  logic [31:0]          file_pos;
  logic [31:0]          pix_offset;
  logic [31:0]          dib_size;
  logic [31:0]          img_width;
  logic [31:0]          img_height;
  logic [31:0]          compression;
  logic [15:0]          signature;
  logic [15:0]          planes;
  logic [15:0]          bpp;
  bmpd_pkg::status_e    hdr_status;
  int unsigned          rows_done;
  int unsigned          cols_done;
  int unsigned          stride_pos;
  logic [7:0]           blue_byte;
  logic [7:0]           green_byte;
  bmpd_pkg::result_t    decoded_q[$];
  int                   errors;
  int                   pixels_seen;
  int                   reports_seen;

  assign error_count_o  = errors;
  assign pixels_seen_o  = pixels_seen;
  assign reports_seen_o = reports_seen;

  task automatic restart_file();
    file_pos    = '0;
    pix_offset  = '0;
    dib_size    = '0;
    img_width   = '0;
    img_height  = '0;
    compression = '0;
    signature   = '0;
    planes      = '0;
    bpp         = '0;
    hdr_status  = bmpd_pkg::StOk;
    rows_done   = 0;
    cols_done   = 0;
    stride_pos  = 0;
    blue_byte   = '0;
    green_byte  = '0;
  endtask

  function automatic logic [15:0] to_rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // little-endian header fields by byte position
  task automatic gather_header(input logic [7:0] b);
    int p;
    p = int'(file_pos);
    if (p <= 1) begin
      signature[p*8 +: 8] = b;
    end else if (p >= 10 && p <= 13) begin
      pix_offset[(p-10)*8 +: 8] = b;
    end else if (p >= 14 && p <= 17) begin
      dib_size[(p-14)*8 +: 8] = b;
    end else if (p >= 18 && p <= 21) begin
      img_width[(p-18)*8 +: 8] = b;
    end else if (p >= 22 && p <= 25) begin
      img_height[(p-22)*8 +: 8] = b;
    end else if (p >= 26 && p <= 27) begin
      planes[(p-26)*8 +: 8] = b;
    end else if (p >= 28 && p <= 29) begin
      bpp[(p-28)*8 +: 8] = b;
    end else if (p >= 30 && p <= 33) begin
      compression[(p-30)*8 +: 8] = b;
    end
  endtask

  // first failing check wins
  task automatic check_header();
    logic [31:0] mag;
    mag = img_height[31] ? (32'd0 - img_height) : img_height;
    if (signature != bmpd_pkg::BmpSignature) hdr_status = bmpd_pkg::StSignature;
    else if (dib_size < bmpd_pkg::MinDibSize) hdr_status = bmpd_pkg::StDib;
    else if (planes != bmpd_pkg::PlaneCount || compression != 32'd0 ||
             bpp != bmpd_pkg::BitsPerPixel)
      hdr_status = bmpd_pkg::StFormat;
    else if (img_width != 32'(bmpd_pkg::ImageWidth) || mag != 32'(bmpd_pkg::ImageHeight))
      hdr_status = bmpd_pkg::StSize;
    else if (pix_offset < 32'(bmpd_pkg::HdrLen)) hdr_status = bmpd_pkg::StOffset;
    else hdr_status = bmpd_pkg::StOk;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    bmpd_pkg::result_t pix;
    bmpd_pkg::result_t rep;
    bit                got_pix;
    got_pix = 1'b0;
    pix     = '0;
    rep     = '0;
    if (file_pos < 32'(bmpd_pkg::HdrLen)) begin
      gather_header(b);
      if (file_pos == 32'(bmpd_pkg::HdrLen - 1)) check_header();
    end else if (hdr_status == bmpd_pkg::StOk && file_pos >= pix_offset &&
                 rows_done < bmpd_pkg::ImageHeight) begin
      if (stride_pos < bmpd_pkg::RowPixelBytes) begin
        case (stride_pos % 3)
          0: blue_byte = b;
          1: green_byte = b;
          default: begin
            pix.kind   = bmpd_pkg::KindPixel;
            // bottom-up files store the bottom display row, the highest row number, first
            pix.row    = img_height[31] ? 6'(rows_done)
                                        : 6'(bmpd_pkg::ImageHeight - 1 - rows_done);
            pix.col    = 6'(cols_done);
            pix.color  = swap_rb ? to_rgb565(blue_byte, green_byte, b)
                                 : to_rgb565(b, green_byte, blue_byte);
            pix.status = bmpd_pkg::StOk;
            got_pix    = 1'b1;
            cols_done  = (cols_done + 1) & 255;
          end
        endcase
      end
      stride_pos++;
      if (stride_pos >= bmpd_pkg::RowStride) begin
        stride_pos = 0;
        rows_done++;
        cols_done = 0;
      end
    end
    if (file_pos != '1) file_pos++;

    pix.last = got_pix && !eof;
    if (got_pix) decoded_q.push_back(pix);
    if (eof) begin
      rep.kind = bmpd_pkg::KindStatus;
      if (file_pos < 32'(bmpd_pkg::HdrLen)) rep.status = bmpd_pkg::StShort;
      else if (hdr_status != bmpd_pkg::StOk) rep.status = hdr_status;
      else if (rows_done < bmpd_pkg::ImageHeight) rep.status = bmpd_pkg::StTruncated;
      else rep.status = bmpd_pkg::StOk;
      rep.last = 1'b1;
      decoded_q.push_back(rep);
      restart_file();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    bmpd_pkg::result_t want;
    if (decoded_q.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected result item, expected nothing, %s 0x%h tuser %b tlast %b",
               $time, "actual tdata", m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end else begin
      want = decoded_q.pop_front();
      check_field("result kind", 32'(want.kind), 32'(m_axis_tuser));
      check_field("pixel row", 32'(want.row), 32'(m_axis_tdata[5:0]));
      check_field("pixel column", 32'(want.col), 32'(m_axis_tdata[11:6]));
      check_field("pixel color", 32'(want.color), 32'(m_axis_tdata[27:12]));
      check_field("status code", 32'(want.status), 32'(m_axis_tdata[30:28]));
      check_field("tdata pad bit", 32'd0, 32'(m_axis_tdata[31]));
      check_field("last result", 32'(want.last), 32'(m_axis_tlast));
      if (want.kind == bmpd_pkg::KindPixel) pixels_seen++;
      else reports_seen++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_file();
      swap_rb = 1'b0;
      decoded_q.delete();
      errors       = 0;
      pixels_seen  = 0;
      reports_seen = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) swap_rb = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: tb/bmp24_to_rgb565_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream_decoder_tb: stimulus and verdict for the bmp decoder
// feeds directed and random bmp files byte by byte with random gaps and
// result stalls, flips the red/blue swap between files, checker scores it
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_stream_decoder_tb;

  localparam logic [31:0] HeightBottomUp = 32'(bmpd_pkg::ImageHeight);
  localparam logic [31:0] HeightTopDown  = 32'd0 - 32'(bmpd_pkg::ImageHeight);
  localparam int          DrainCycles    = 8;
  localparam int          RandomBytes    = 300;
  // one pure blue, one pure green and one pure red pixel, stored as b, g, r
  localparam logic [7:0]  CornerBytes [9] = '{8'hFF, 8'h00, 8'h00,
                                              8'h00, 8'hFF, 8'h00,
                                              8'h00, 8'h00, 8'hFF};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;

  int error_count;
  int pending;
  int pixels_seen;
  int reports_seen;

  logic [7:0] file_q[$];     // bytes of the file being built
  int         bytes_sent;
  int         files_sent;
  int         send_burst;
  int         recv_burst;
  int         stall_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bmp24_to_rgb565_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  bmpd_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .pixels_seen_o  (pixels_seen),
    .reports_seen_o (reports_seen)
  );

  // wait before the next item: drawn at random, with gap-free bursts now and then
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(20, 150);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // receiver: after each taken result item, hold tready low for a drawn stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left = 0;
      recv_burst = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) stall_left = draw_wait(recv_burst);
      else if (stall_left > 0) stall_left--;
      m_axis_tready <= (stall_left == 0);
    end
  end

  // one file byte, held until the slave side takes it
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // the whole built file, end of file on its final byte
  task automatic send_file();
    int n;
    n = file_q.size();
    for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    file_q.delete();
    files_sent++;
  endtask

  // stop sending until every predicted result has come out, then drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_swap(input logic swap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= swap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic put_le(input int pos, input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_q[pos + i] = value[8*i +: 8];
  endtask

  // 54 header bytes, random where unread, then filler up to an offset below 300
  task automatic build_header(input logic [15:0] sig, input logic [31:0] dib,
                              input logic [31:0] wid, input logic [31:0] hgt,
                              input logic [15:0] pl, input logic [15:0] bp,
                              input logic [31:0] comp, input logic [31:0] offs);
    file_q.delete();
    repeat (bmpd_pkg::HdrLen) file_q.push_back(8'($urandom));
    put_le(0, 32'(sig), 2);
    put_le(10, offs, 4);
    put_le(14, dib, 4);
    put_le(18, wid, 4);
    put_le(22, hgt, 4);
    put_le(26, 32'(pl), 2);
    put_le(28, 32'(bp), 2);
    put_le(30, comp, 4);
    if (offs > 32'(bmpd_pkg::HdrLen) && offs < 32'd300)
      for (int i = bmpd_pkg::HdrLen; i < int'(offs); i++) file_q.push_back(8'($urandom));
  endtask

  task automatic good_header(input logic [31:0] hgt, input logic [31:0] offs);
    build_header(bmpd_pkg::BmpSignature, bmpd_pkg::MinDibSize, 32'(bmpd_pkg::ImageWidth),
                 hgt, bmpd_pkg::PlaneCount, bmpd_pkg::BitsPerPixel, 32'd0, offs);
  endtask

  // a header with one field, or width and height, redrawn at random
  task automatic broken_header();
    logic [15:0] sig;
    logic [15:0] pl;
    logic [15:0] bp;
    logic [31:0] dib;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [31:0] comp;
    logic [31:0] offs;
    sig  = bmpd_pkg::BmpSignature;
    pl   = bmpd_pkg::PlaneCount;
    bp   = bmpd_pkg::BitsPerPixel;
    dib  = bmpd_pkg::MinDibSize;
    wid  = 32'(bmpd_pkg::ImageWidth);
    hgt  = $urandom_range(0, 1) ? HeightBottomUp : HeightTopDown;
    comp = 32'd0;
    offs = 32'(bmpd_pkg::HdrLen);
    case ($urandom_range(0, 6))
      0: sig = 16'($urandom);
      1: dib = $urandom_range(0, 39);
      2: pl = 16'($urandom_range(0, 3));
      3: bp = 16'($urandom_range(0, 48));
      4: comp = $urandom;
      5: begin
        wid = $urandom_range(0, 130);
        if ($urandom_range(0, 1) == 1) hgt = $urandom;
      end
      default: offs = $urandom_range(0, 53);
    endcase
    build_header(sig, dib, wid, hgt, pl, bp, comp, offs);
  endtask

  // pixel area bytes; a negative fill means random
  task automatic add_pixels(input int n, input int fill);
    repeat (n) file_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic make_noise(input int n);
    file_q.delete();
    add_pixels(n, -1);
  endtask

  task automatic truncate_to(input int n);
    while (file_q.size() > n) void'(file_q.pop_back());
  endtask

  initial begin : stimulus
    int rnd_bytes;
    int pick;
    bytes_sent = 0;
    files_sent = 0;
    send_burst = 0;
    rnd_bytes  = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_swap(1'b0);

    // short files: end of file on the first byte and one byte short of a header
    make_noise(1);
    send_file();
    good_header(HeightBottomUp, 32'(bmpd_pkg::HdrLen));
    truncate_to(bmpd_pkg::HdrLen - 1);
    send_file();
    // header alone, so the pixel area is missing
    good_header(HeightBottomUp, 32'(bmpd_pkg::HdrLen));
    send_file();

    // each header check failing in turn, pixel bytes after it must stay silent
    build_header(16'h424D, bmpd_pkg::MinDibSize, 32'(bmpd_pkg::ImageWidth), HeightBottomUp,
                 bmpd_pkg::PlaneCount, bmpd_pkg::BitsPerPixel, 32'd0,
                 32'(bmpd_pkg::HdrLen));
    add_pixels(6, -1);
    send_file();
    build_header(bmpd_pkg::BmpSignature, 32'd39, 32'(bmpd_pkg::ImageWidth), HeightBottomUp,
                 bmpd_pkg::PlaneCount, bmpd_pkg::BitsPerPixel, 32'd0,
                 32'(bmpd_pkg::HdrLen));
    add_pixels(6, -1);
    send_file();
    build_header(bmpd_pkg::BmpSignature, bmpd_pkg::MinDibSize, 32'(bmpd_pkg::ImageWidth),
                 HeightTopDown, 16'd2, bmpd_pkg::BitsPerPixel, 32'd0,
                 32'(bmpd_pkg::HdrLen));
    send_file();
    build_header(bmpd_pkg::BmpSignature, bmpd_pkg::MinDibSize, 32'(bmpd_pkg::ImageWidth),
                 HeightTopDown, bmpd_pkg::PlaneCount, 16'd32, 32'd0,
                 32'(bmpd_pkg::HdrLen));
    send_file();
    build_header(bmpd_pkg::BmpSignature, bmpd_pkg::MinDibSize, 32'(bmpd_pkg::ImageWidth),
                 HeightBottomUp, bmpd_pkg::PlaneCount, bmpd_pkg::BitsPerPixel, 32'd1,
                 32'(bmpd_pkg::HdrLen));
    send_file();
    build_header(bmpd_pkg::BmpSignature, bmpd_pkg::MinDibSize,
                 32'(bmpd_pkg::ImageWidth - 1), HeightBottomUp, bmpd_pkg::PlaneCount,
                 bmpd_pkg::BitsPerPixel, 32'd0, 32'(bmpd_pkg::HdrLen));
    send_file();
    good_header(32'(bmpd_pkg::ImageHeight + 1), 32'(bmpd_pkg::HdrLen));
    send_file();
    // most negative height has no positive twin, so it never matches
    good_header(32'h8000_0000, 32'(bmpd_pkg::HdrLen));
    send_file();
    // pixel offset pointing back into the header
    good_header(HeightBottomUp, 32'(bmpd_pkg::HdrLen - 1));
    add_pixels(9, -1);
    send_file();
    good_header(HeightTopDown, 32'd0);
    add_pixels(9, -1);
    send_file();
    // offset past the end of the file: nothing but truncated
    good_header(HeightBottomUp, 32'hFFFF_FFFF);
    add_pixels(30, -1);
    send_file();
    // largest dib size with a few pixels
    build_header(bmpd_pkg::BmpSignature, 32'hFFFF_FFFF, 32'(bmpd_pkg::ImageWidth),
                 HeightTopDown, bmpd_pkg::PlaneCount, bmpd_pkg::BitsPerPixel, 32'd0,
                 32'(bmpd_pkg::HdrLen));
    add_pixels(7, -1);
    send_file();

    // color extremes in both swap settings
    for (int s = 0; s < 2; s++) begin
      wait_idle();
      write_swap(s[0]);
      good_header(HeightBottomUp, 32'(bmpd_pkg::HdrLen + 3));
      add_pixels(3, 8'hFF);
      add_pixels(3, 8'h00);
      foreach (CornerBytes[i]) file_q.push_back(CornerBytes[i]);
      send_file();
    end

    // partial images across a row boundary: bottom-up, then top-down after filler
    good_header(HeightBottomUp, 32'(bmpd_pkg::HdrLen));
    add_pixels(int'(bmpd_pkg::RowStride) + 6, -1);
    send_file();
    wait_idle();
    write_swap(1'b0);
    good_header(HeightTopDown, 32'(bmpd_pkg::HdrLen + 7));
    add_pixels(int'(bmpd_pkg::RowStride) + 9, -1);
    send_file();

    // random files: mostly well formed with random pixels, some broken, some noise
    while (rnd_bytes < RandomBytes) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        good_header($urandom_range(0, 1) ? HeightBottomUp : HeightTopDown,
                    32'(bmpd_pkg::HdrLen + $urandom_range(0, 12)));
        if ($urandom_range(0, 1) == 1) put_le(14, $urandom_range(40, 1000), 4);
        add_pixels($urandom_range(0, 200), -1);
        if ($urandom_range(0, 9) == 0) truncate_to($urandom_range(1, file_q.size()));
      end else if (pick <= 8) begin
        broken_header();
        add_pixels($urandom_range(0, 30), -1);
      end else begin
        make_noise($urandom_range(1, 70));
      end
      rnd_bytes += file_q.size();
      send_file();
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        write_swap(1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    $display("run covered %0d files in %0d bytes: %0d pixel items and %0d status items",
             files_sent, bytes_sent, pixels_seen, reports_seen);
    $display("header checks, offsets, truncation, both row orders and both swap settings");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d result items still expected", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
